FILE: hw/rtl/wsd_pkg.sv
// Shared types and constants for the frame deframer.
// Holds result kinds, error codes, queue sizing and the queue entry type.
`default_nettype none

package wsd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] MaxFrameReset = 32'd1048576;
  localparam logic [6:0]  Len16Code     = 7'd126;
  localparam logic [6:0]  Len64Code     = 7'd127;
  localparam logic [63:0] CtrlMaxLen    = 64'd125;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_RESERVED = 2'd0,
    ERR_UNMASKED = 2'd1,
    ERR_CONTROL  = 2'd2,
    ERR_TOO_BIG  = 2'd3
  } err_e;

  // One classified transaction, waiting for the back end.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    err_e       err;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wsd_front.sv
// Front end: accepts stream bytes, walks the frame header and classifies bytes.
// Depends on wsd_pkg; pushes one entry_t per result into the queue.
`default_nettype none

module wsd_front
  import wsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  typedef enum logic [2:0] {
    PH_HDR0     = 3'd0,
    PH_HDR1     = 3'd1,
    PH_HDR1_BAD = 3'd2,
    PH_EXTLEN   = 3'd3,
    PH_KEY      = 3'd4,
    PH_PAYLOAD  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] max_q;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  key_left_q, key_left_d;
  logic [31:0] pay_left_q, pay_left_d;
  logic [1:0]  idx_q, idx_d;

  logic        accept;
  logic        has_res;
  entry_t      ent;
  logic [63:0] len_chk;
  logic        chk_len;
  logic [63:0] ext_acc;
  logic [3:0]  ext_dec;
  logic [2:0]  key_dec;
  logic [31:0] key_shift;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept & has_res;
  assign q_entry_o  = ent;

  assign ext_acc   = {len_q[55:0], in_byte_i};
  assign ext_dec   = (ext_left_q != 4'd0) ? ext_left_q - 4'd1 : 4'd0;
  assign key_dec   = (key_left_q != 3'd0) ? key_left_q - 3'd1 : 3'd0;
  assign key_shift = {key_q[23:0], in_byte_i};

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    fin_d      = fin_q;
    ext_left_d = ext_left_q;
    len_d      = len_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    pay_left_d = pay_left_q;
    idx_d      = idx_q;
    has_res    = 1'b0;
    chk_len    = 1'b0;
    len_chk    = '0;
    ent.kind     = KIND_ERROR;
    ent.raw_byte = '0;
    ent.key_byte = '0;
    ent.opcode   = opcode_q;
    ent.fin      = fin_q;
    ent.last     = 1'b0;
    ent.err      = ERR_RESERVED;

    unique case (phase_q)
      PH_HDR1, PH_HDR1_BAD: begin
        if (phase_q == PH_HDR1_BAD) begin
          has_res = 1'b1;
          ent.err = ERR_RESERVED;
          phase_d = PH_HDR0;
        end else if (!in_byte_i[7]) begin
          has_res = 1'b1;
          ent.err = ERR_UNMASKED;
          phase_d = PH_HDR0;
        end else if (in_byte_i[6:0] == Len16Code) begin
          len_d      = '0;
          ext_left_d = 4'd2;
          phase_d    = PH_EXTLEN;
        end else if (in_byte_i[6:0] == Len64Code) begin
          len_d      = '0;
          ext_left_d = 4'd8;
          phase_d    = PH_EXTLEN;
        end else begin
          len_d   = {57'd0, in_byte_i[6:0]};
          len_chk = {57'd0, in_byte_i[6:0]};
          chk_len = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_d      = ext_acc;
        ext_left_d = ext_dec;
        if (ext_dec == 4'd0) begin
          len_chk = ext_acc;
          chk_len = 1'b1;
        end
      end
      PH_KEY: begin
        key_d      = key_shift;
        key_left_d = key_dec;
        if (key_dec == 3'd0) begin
          idx_d = 2'd0;
          if (pay_left_q == 32'd0) begin
            has_res  = 1'b1;
            ent.kind = KIND_EMPTY;
            ent.last = 1'b1;
            phase_d  = PH_HDR0;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_res      = 1'b1;
        ent.kind     = KIND_DATA;
        ent.raw_byte = in_byte_i;
        ent.key_byte = key_q[{2'd3 - idx_q, 3'd0} +: 8];
        idx_d        = idx_q + 2'd1;
        pay_left_d   = (pay_left_q != 32'd0) ? pay_left_q - 32'd1 : 32'd0;
        ent.last     = (pay_left_q <= 32'd1);
        if (pay_left_q <= 32'd1) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        fin_d    = in_byte_i[7];
        opcode_d = in_byte_i[3:0];
        phase_d  = (in_byte_i[6:4] != 3'd0) ? PH_HDR1_BAD : PH_HDR1;
      end
    endcase

    if (chk_len) begin
      if (opcode_q[3] && (len_chk > CtrlMaxLen)) begin
        has_res = 1'b1;
        ent.err = ERR_CONTROL;
        phase_d = PH_HDR0;
      end else if ((len_chk[63:32] != 32'd0) || (len_chk[31:0] > max_q)) begin
        has_res = 1'b1;
        ent.err = ERR_TOO_BIG;
        phase_d = PH_HDR0;
      end else begin
        pay_left_d = len_chk[31:0];
        key_d      = '0;
        key_left_d = 3'd4;
        phase_d    = PH_KEY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      max_q      <= MaxFrameReset;
      opcode_q   <= '0;
      fin_q      <= 1'b0;
      ext_left_q <= '0;
      len_q      <= '0;
      key_q      <= '0;
      key_left_q <= '0;
      pay_left_q <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        max_q <= cfg_wr_data_i;
      end
      if (accept) begin
        phase_q    <= phase_d;
        opcode_q   <= opcode_d;
        fin_q      <= fin_d;
        ext_left_q <= ext_left_d;
        len_q      <= len_d;
        key_q      <= key_d;
        key_left_q <= key_left_d;
        pay_left_q <= pay_left_d;
        idx_q      <= idx_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_fifo.sv
// Short queue of classified entries between front and back ends.
// Depends on wsd_pkg for entry_t and depth constants.
`default_nettype none

module wsd_fifo
  import wsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    push_entry_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output entry_t    head_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_back.sv
// Back end: unmasks queued entries and holds the output register.
// Depends on wsd_pkg; pops the queue whenever the output slot frees up.
`default_nettype none

module wsd_back
  import wsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  entry_t           q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output kind_e            out_kind_o,
  output logic [7:0]       out_data_o,
  output logic [3:0]       out_opcode_o,
  output logic             out_fin_o,
  output logic             out_last_o,
  output err_e             out_err_o
);

  logic valid_q;

  assign q_pop_o     = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_kind_o   <= q_head_i.kind;
      out_data_o   <= q_head_i.raw_byte ^ q_head_i.key_byte;
      out_opcode_o <= q_head_i.opcode;
      out_fin_o    <= q_head_i.fin;
      out_last_o   <= q_head_i.last;
      out_err_o    <= q_head_i.err;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer.sv
// Top level of the client-to-server frame deframer.
// Instantiates wsd_front, wsd_fifo and wsd_back; uses wsd_pkg.
//
// Takes one stream byte per cycle and produces at most one result per byte:
// a payload byte with its mask removed, an empty-frame marker, or a frame
// error (tuser = 0, 1, 2). Header parsing and length checks are done as each
// byte arrives; results pass through a four-entry queue into a registered
// output, so input keeps flowing while the sink stalls until the queue fills.
// Sustained rate is one byte per cycle while the queue has room; each result
// is queued and then registered. After an error the next byte is parsed as
// a new first header byte. max_frame_size is written through cfg_wr_en_i /
// cfg_wr_data_i (reset 1048576) and must only change while the block is idle.
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] data_byte, [11:8] opcode,
                                             // [12] fin, [14:13] error_code
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o
);

  logic   q_full, q_push, q_pop, q_valid;
  entry_t q_in, q_head;
  kind_e  out_kind;
  err_e   out_err;
  logic [7:0] out_data;
  logic [3:0] out_opcode;
  logic   out_fin;

  wsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_byte_i     (s_axis_tdata_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  wsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  wsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_kind_o   (out_kind),
    .out_data_o   (out_data),
    .out_opcode_o (out_opcode),
    .out_fin_o    (out_fin),
    .out_last_o   (m_axis_tlast_o),
    .out_err_o    (out_err)
  );

  assign m_axis_tdata_o = {1'b0, out_err, out_fin, out_opcode, out_data};
  assign m_axis_tuser_o = out_kind;

endmodule

`default_nettype wire
